// ===== design/scb_pkg.sv =====
package scb_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int KEY_COUNT  = 128;
    localparam int KEY_W      = $clog2(KEY_COUNT);
    localparam int CODE_W     = 8;
    localparam int KIDX_W     = 7;
    localparam int REQ_W      = 3;
    localparam int TABLE_LEN  = 84;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [6:0] CODE_LSHIFT = 7'h2A;
    localparam logic [6:0] CODE_RSHIFT = 7'h36;
    localparam logic [6:0] CODE_ALT    = 7'h38;

    typedef enum logic [REQ_W-1:0] {
        REQ_SCAN  = 3'd0,
        REQ_READ  = 3'd1,
        REQ_ALT   = 3'd2,
        REQ_CLEAR = 3'd3,
        REQ_QUERY = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_FETCH = 3'b100
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;      // latch the accepted request
        logic commit_op;    // apply a non-read request and load the result
        logic commit_read;  // load the fetched character and advance the read pointer
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_read;
    } status_t;

    // One result, lowest field in the lowest bits.
    typedef struct packed {
        logic       snapshot_pulse;
        logic       key_down;
        logic       alt_seen;
        logic       char_valid;
        logic [7:0] char_out;
    } result_t;

    localparam logic [7:0] LOWER_TAB [0:TABLE_LEN-1] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D,
        8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D,
        8'h0A, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h6C, 8'h3B, 8'h27, 8'h60,
        8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
        8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h26, 8'h00, 8'h2D, 8'h25, 8'h00, 8'h27, 8'h2B, 8'h00,
        8'h28, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] UPPER_TAB [0:TABLE_LEN-1] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B,
        8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D,
        8'h0A, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h4C, 8'h3A, 8'h22, 8'h7E,
        8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
        8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00
    };

    // Codes past the end of the tables map to zero.
    function automatic logic [7:0] char_lookup(input logic [6:0] key, input logic shift);
        logic [7:0] ch;
        ch = 8'h00;
        if (int'(key) < TABLE_LEN) begin
            ch = shift ? UPPER_TAB[key] : LOWER_TAB[key];
        end
        return ch;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

endpackage

// ===== design/scb_ctrl.sv =====
module scb_ctrl
    import scb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    m_tready,
    output logic    m_tvalid,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The output register can take a result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.is_read) begin
                    state_next = ST_FETCH;
                end else if (out_free) begin
                    cmd.commit_op = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FETCH: begin
                if (out_free) begin
                    cmd.commit_read = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.commit_op || cmd.commit_read) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/scb_dp.sv =====
module scb_dp
    import scb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [REQ_W-1:0]      req_in,
    input  logic [CODE_W-1:0]     code_in,
    input  logic [KIDX_W-1:0]     kidx_in,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [M_TDATA_W-1:0]  result_data
);

    logic [REQ_W-1:0]  req_reg;
    logic [CODE_W-1:0] code_reg;
    logic [KIDX_W-1:0] kidx_reg;

    logic                 shift_reg, shift_next;
    logic                 alt_reg, alt_next;
    logic [PTR_W-1:0]     wptr_reg, wptr_next;
    logic [PTR_W-1:0]     rptr_reg, rptr_next;
    logic [KEY_COUNT-1:0] keymap_reg, keymap_next;

    logic [7:0] ring [0:RING_DEPTH-1];
    logic [7:0] rd_data_reg;
    logic       ring_we;
    logic [7:0] push_char;

    result_t out_reg, out_next;

    logic [6:0]       key;
    logic             is_break;
    logic             shift_code;
    logic [PTR_W-1:0] wptr_inc;

    assign key        = code_reg[6:0];
    assign is_break   = code_reg[7];
    assign shift_code = (key == CODE_LSHIFT) || (key == CODE_RSHIFT);
    assign wptr_inc   = ptr_next(wptr_reg);
    assign push_char  = char_lookup(key, shift_reg);

    assign status.is_read = (req_reg == REQ_READ);
    assign result_data    = M_TDATA_W'(out_reg);

    always_comb begin
        shift_next  = shift_reg;
        alt_next    = alt_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        keymap_next = keymap_reg;
        out_next    = out_reg;
        ring_we     = 1'b0;
        if (cmd.commit_op) begin
            out_next = '0;
            case (req_reg)
                REQ_SCAN: begin
                    keymap_next[KEY_W'(key)] = !is_break;
                    if (is_break) begin
                        if (shift_code) begin
                            shift_next = 1'b0;
                        end
                    end else if (shift_code) begin
                        shift_next = 1'b1;
                    end else if (key == CODE_ALT) begin
                        alt_next                = 1'b1;
                        out_next.snapshot_pulse = 1'b1;
                    end else begin
                        ring_we   = 1'b1;
                        wptr_next = wptr_inc;
                        // A full ring drops its oldest character.
                        if (wptr_inc == rptr_reg) begin
                            rptr_next = ptr_next(rptr_reg);
                        end
                    end
                end
                REQ_ALT: begin
                    out_next.alt_seen = alt_reg;
                    alt_next          = 1'b0;
                end
                REQ_CLEAR: begin
                    wptr_next = '0;
                    rptr_next = '0;
                end
                REQ_QUERY: begin
                    out_next.key_down = keymap_reg[KEY_W'(kidx_reg)];
                end
                default: ;
            endcase
        end else if (cmd.commit_read) begin
            out_next = '0;
            if (rptr_reg != wptr_reg) begin
                out_next.char_out   = rd_data_reg;
                out_next.char_valid = 1'b1;
                rptr_next           = ptr_next(rptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= req_in;
            code_reg <= code_in;
            kidx_reg <= kidx_in;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring[wptr_reg] <= push_char;
        end
        rd_data_reg <= ring[rptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= 1'b0;
            alt_reg    <= 1'b0;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            keymap_reg <= '0;
        end else begin
            shift_reg  <= shift_next;
            alt_reg    <= alt_next;
            wptr_reg   <= wptr_next;
            rptr_reg   <= rptr_next;
            keymap_reg <= keymap_next;
        end
    end

endmodule

// ===== design/scancode_to_char_buffer.sv =====
// Keyboard scancode decoder with a character ring buffer.
// Requests enter on the s_ stream: s_tuser carries the request kind (scancode,
// read character, read and clear the alt flag, clear the ring, query a key) and
// s_tdata carries the scancode byte and the key number for a query.
// Each request produces exactly one result on the m_ stream, whose m_tdata holds
// the character read, its valid flag, the alt flag seen, the queried key state
// and the snapshot pulse raised by an alt make code; unused fields are zero.
// After acceptance a request passes an execute state, and a read-character request
// also a fetch state for the registered read port of the ring memory, before its
// result is loaded into the output register and m_tvalid rises. One request is in
// work at a time, so the block takes no new request until the last one is loaded.
// A finished result sits in an output register; the next request is accepted
// while it waits, and only its own completion waits for m_tready, so a stalled
// receiver holds the block after at most one more request.
// Reset (aresetn low, synchronous) clears the shift and alt flags, both ring
// pointers, the key map and the output valid flag. The ring storage itself is
// not cleared; the pointers ensure only written entries are ever read.
module scancode_to_char_buffer
    import scb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] scan_code, [14:8] key_index, [15] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] req_type
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] char_out, [8] char_valid, [9] alt_seen, [10] key_down,
    // [11] snapshot_pulse, [15:12] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    cmd_t    cmd;
    status_t status;

    // Sequencing of each request and ownership of the output valid flag.
    scb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    // Flags, key map, ring pointers, ring memory and the output register.
    scb_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_in      (s_tuser),
        .code_in     (s_tdata[CODE_W-1:0]),
        .kidx_in     (s_tdata[CODE_W +: KIDX_W]),
        .cmd         (cmd),
        .status      (status),
        .result_data (m_tdata)
    );

    // Only one request is in work, so an accepted request closes the input.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in work");

    // A result never carries both a read character and a snapshot pulse.
    a_exclusive_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[8] && m_tdata[11]))
        else $error("result mixes a character read with a snapshot pulse");

    // A result marked invalid for a character carries no character.
    a_empty_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == 8'h00))
        else $error("nonzero character without its valid flag");

    // A non-read request shows its result, committed from the execute state, when
    // the output side was free at acceptance.
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser != REQ_READ) && (!m_tvalid || m_tready))
        |-> ##2 m_tvalid)
        else $error("result missing after a request");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import scb_pkg::*;

    // The ignored request kinds sit above the last defined one.
    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

    // Cycles with no handshake on either side before the run is declared hung.
    // The longest correct quiet spell is the receiver hold below.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 250;
    localparam int SHOW_MAX    = 20;

    // Set-1 make code to character, without and with shift held.
    localparam logic [7:0] KEY_LOWER [0:TABLE_LEN-1] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
        8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
        8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h26, 8'h00, 8'h2D, 8'h25, 8'h00, 8'h27, 8'h2B, 8'h00, 8'h28, 8'h00, 8'h00, 8'h00
    };
    localparam logic [7:0] KEY_UPPER [0:TABLE_LEN-1] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
        8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
        8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Keyboard state mirror plus the queue of results still owed by the block.
    // Every accepted request owes exactly one result, in request order.
    class keyboard_scoreboard;
        bit               shift_on;
        bit               alt_flag;
        logic [PTR_W-1:0] wr_ptr;
        logic [PTR_W-1:0] rd_ptr;
        bit [7:0]         ring [RING_DEPTH];
        bit               key_state [KEY_COUNT];
        result_t          owed_q [$];
        int               errors;
        int               results;
        int               pushes;
        int               overwrites;
        int               chars_read;
        int               snapshots;
        int               shown;

        function new();
            wr_ptr = '0;
            rd_ptr = '0;
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [7:0] code,
                                   logic [6:0] kidx);
            result_t    r;
            logic [6:0] key;
            logic [7:0] ch;
            r   = '0;
            key = code[6:0];
            case (kind)
                REQ_SCAN: begin
                    if (!code[7]) begin
                        key_state[key] = 1'b1;
                        if (key == CODE_LSHIFT || key == CODE_RSHIFT) begin
                            shift_on = 1'b1;
                        end else if (key == CODE_ALT) begin
                            alt_flag         = 1'b1;
                            r.snapshot_pulse = 1'b1;
                            snapshots++;
                        end else begin
                            ch = 8'h00;
                            if (int'(key) < TABLE_LEN) begin
                                ch = shift_on ? KEY_UPPER[key] : KEY_LOWER[key];
                            end
                            // A full ring drops its oldest character.
                            ring[wr_ptr] = ch;
                            if (wr_ptr + PTR_W'(1) == rd_ptr) begin
                                rd_ptr++;
                                overwrites++;
                            end
                            wr_ptr++;
                            pushes++;
                        end
                    end else begin
                        key_state[key] = 1'b0;
                        // Releasing either shift key drops shift, even if the other is held.
                        if (key == CODE_LSHIFT || key == CODE_RSHIFT) begin
                            shift_on = 1'b0;
                        end
                    end
                end
                REQ_READ: begin
                    if (rd_ptr != wr_ptr) begin
                        r.char_out   = ring[rd_ptr];
                        r.char_valid = 1'b1;
                        rd_ptr++;
                    end
                end
                REQ_ALT: begin
                    r.alt_seen = alt_flag;
                    alt_flag   = 1'b0;
                end
                REQ_CLEAR: begin
                    wr_ptr = '0;
                    rd_ptr = '0;
                end
                REQ_QUERY: begin
                    r.key_down = key_state[kidx];
                end
                default: begin
                end
            endcase
            owed_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                if (shown < SHOW_MAX) begin
                    shown++;
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
                end
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            result_t got;
            result_t want;
            results++;
            got = result_t'(data[$bits(result_t)-1:0]);
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding, expected none, actual %0h",
                         $time, data);
                return;
            end
            want = owed_q.pop_front();
            if (want.char_valid) begin
                chars_read++;
            end
            compare_field("char_out", want.char_out, got.char_out);
            compare_field("char_valid", want.char_valid, got.char_valid);
            compare_field("alt_seen", want.alt_seen, got.alt_seen);
            compare_field("key_down", want.key_down, got.key_down);
            compare_field("snapshot_pulse", want.snapshot_pulse, got.snapshot_pulse);
            compare_field("padding", 0, data[M_TDATA_W-1:$bits(result_t)]);
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    keyboard_scoreboard sb;
    int         tx_idle_pct  = 0;
    int         rx_idle_pct  = 0;
    int         sent_count   = 0;
    int         quiet_cycles = 0;
    bit         hold_pending = 1'b0;
    logic [6:0] last_key     = '0;

    scancode_to_char_buffer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Offers one request, after a random number of idle cycles, and returns at the
    // edge where it is taken. tvalid stays high on return so back-to-back requests
    // need no extra assignment; the next call either keeps or drops it.
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [7:0] code,
                                input logic [6:0] kidx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            s_tuser  <= REQ_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, kidx, code};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_request(kind, code, kidx);
        sent_count++;
    endtask

    task automatic send_scan(input logic [7:0] code);
        send_request(REQ_SCAN, code, 7'($urandom));
    endtask

    // Any key but the modifiers; most come from inside the character tables.
    function automatic logic [6:0] plain_key();
        logic [6:0] k;
        do begin
            if ($urandom_range(9) == 0) begin
                k = 7'($urandom_range(TABLE_LEN, KEY_COUNT - 1));
            end else begin
                k = 7'($urandom_range(0, TABLE_LEN - 1));
            end
        end while (k == CODE_LSHIFT || k == CODE_RSHIFT || k == CODE_ALT);
        return k;
    endfunction

    // A realistic burst of typing: optional alt and shift around a few key
    // presses, with some keys left held and some queried while down.
    task automatic type_burst();
        logic [6:0] shift_key;
        logic [6:0] k;
        bit         shifted;
        bit         with_alt;
        shifted   = ($urandom_range(2) == 0);
        with_alt  = ($urandom_range(5) == 0);
        shift_key = $urandom_range(1) ? CODE_LSHIFT : CODE_RSHIFT;
        if (with_alt) begin
            send_scan({1'b0, CODE_ALT});
        end
        if (shifted) begin
            send_scan({1'b0, shift_key});
        end
        repeat ($urandom_range(1, 6)) begin
            k        = plain_key();
            last_key = k;
            send_scan({1'b0, k});
            if ($urandom_range(3) == 0) begin
                send_request(REQ_QUERY, 8'($urandom), k);
            end
            if ($urandom_range(4) != 0) begin
                send_scan({1'b1, k});
            end
        end
        if (shifted) begin
            send_scan({1'b1, shift_key});
        end
        if (with_alt) begin
            send_scan({1'b1, CODE_ALT});
            send_request(REQ_ALT, 8'($urandom), 7'($urandom));
        end
    endtask

    task automatic random_segment();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            type_burst();
        end else if (pick < 70) begin
            repeat ($urandom_range(1, 6)) begin
                send_request(REQ_READ, 8'($urandom), 7'($urandom));
            end
        end else if (pick < 82) begin
            repeat ($urandom_range(1, 4)) begin
                send_request(REQ_QUERY, 8'($urandom),
                             $urandom_range(1) ? last_key : 7'($urandom));
            end
        end else if (pick < 96) begin
            // Noise: any request kind, the ignored ones included, with raw fields.
            repeat ($urandom_range(1, 3)) begin
                send_request(REQ_W'($urandom_range(REQ_SCAN, REQ_SPARE_LAST)),
                             8'($urandom), 7'($urandom));
            end
        end else begin
            send_request(REQ_CLEAR, 8'($urandom), 7'($urandom));
        end
    endtask

    // Result side: checks every completed handshake and chooses tready for the
    // next cycle. A requested hold keeps tready low for a long counted stretch.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: a run that stops moving on both sides is hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening: empty ring, flags at reset, both shifts, alt latch and
        // release, table edges, ignored request kinds, and clearing the ring.
        send_request(REQ_READ, 8'hFF, 7'h7F);
        send_request(REQ_QUERY, 8'h00, 7'h7F);
        send_request(REQ_ALT, 8'h00, 7'h00);
        send_scan(8'h1E);
        send_scan({1'b0, CODE_LSHIFT});
        send_scan(8'h1E);
        send_scan({1'b1, CODE_LSHIFT});
        send_scan({1'b0, CODE_RSHIFT});
        send_scan(8'h02);
        send_scan({1'b1, CODE_RSHIFT});
        send_scan({1'b0, CODE_ALT});
        // Releasing alt leaves the latched flag set until it is read.
        send_scan({1'b1, CODE_ALT});
        send_request(REQ_ALT, 8'h00, 7'h00);
        send_request(REQ_ALT, 8'hFF, 7'h7F);
        // A zero table entry, the last entry, the first code past the table, and
        // the highest make code all store a character.
        send_scan(8'h00);
        send_scan(8'h53);
        send_scan(8'h54);
        send_scan(8'h7F);
        send_request(REQ_QUERY, 8'hFF, 7'h7F);
        send_scan(8'hFF);
        send_request(REQ_SPARE_FIRST, 8'hFF, 7'h7F);
        send_request(REQ_SPARE_LAST, 8'hFF, 7'h7F);
        send_request(REQ_READ, 8'h00, 7'h00);
        send_request(REQ_READ, 8'h00, 7'h00);
        send_request(REQ_CLEAR, 8'hFF, 7'h7F);
        send_request(REQ_READ, 8'h00, 7'h00);

        // Both sides idle, the sender less than the receiver.
        tx_idle_pct = 36;
        rx_idle_pct = 47;
        while (sent_count < 325) begin
            random_segment();
        end

        // Roles swapped. Open with a flood of make codes and no reads, which
        // fills the ring, overwrites its oldest entries and wraps the write pointer.
        tx_idle_pct = 47;
        rx_idle_pct = 36;
        repeat (280) begin
            send_scan({1'b0, plain_key()});
        end
        while (sent_count < 650) begin
            random_segment();
        end

        // No idling. The receiver first holds off for a long stretch while the
        // sender keeps offering, so the block backs up and stalls its input.
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_pending = 1'b1;
        while (sent_count < 975) begin
            random_segment();
        end
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0) begin
            @(posedge aclk);
        end
        // A few more cycles to catch any stray result.
        repeat (10) @(posedge aclk);

        $display("Covered %0d requests and %0d results: %0d characters queued, %0d read back,",
                 sent_count, sb.results, sb.pushes, sb.chars_read);
        $display("%0d overwrites of a full ring, %0d alt snapshots, %0d mismatches.",
                 sb.overwrites, sb.snapshots, sb.errors);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
